[sv/imm_pkg.sv]
// Shared types, constants and helper functions of the integer matrix multiply block.
`default_nettype none
package imm_pkg;

    localparam int DATA_W        = 32;
    localparam int DIM_W         = 6;
    localparam int IDX_W         = 5;
    localparam int FILL_W        = 13;
    localparam int ADDR_W        = 4;
    localparam int MAX_OUT       = 32;
    localparam int DEF_MAX_DIM   = 32;
    localparam int DEF_B_DEPTH   = 1024;
    localparam int DEF_ROW_DEPTH = 32;

    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    localparam logic FUNC_B = 1'b0;
    localparam logic FUNC_A = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] c_value;
        logic [IDX_W-1:0]  c_row;
        logic [IDX_W-1:0]  c_col;
        logic              row_last;
        logic              matrix_last;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] inner;
        logic [DIM_W-1:0] cols;
    } t_dims;

    typedef struct packed {
        logic             first;
        logic             last;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic             row_last;
        logic             matrix_last;
    } t_tag;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int cap);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > cap) begin
            r = DIM_W'(cap);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/imm_mac.sv]
// Shared multiply-accumulate unit with product and accumulator stages and the result register.
`default_nettype none
module imm_mac (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [31:0]      i_a,
    input  wire logic [31:0]      i_b,
    input  wire imm_pkg::t_tag    i_tag,
    output logic                  o_strobe,
    output imm_pkg::t_out_item    o_result,
    output logic                  o_row_done
);
    import imm_pkg::*;

    logic              r_p_valid;
    logic [DATA_W-1:0] r_prod;
    t_tag              r_p_tag;
    logic [DATA_W-1:0] r_acc;
    logic              r_strobe;
    t_out_item         r_result;
    logic [DATA_W-1:0] n_sum;
    logic [DATA_W-1:0] prod;

    assign prod  = i_a * i_b;
    assign n_sum = r_p_tag.first ? r_prod : r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
            r_strobe  <= r_p_valid && r_p_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= prod;
        r_p_tag <= i_tag;
        if (r_p_valid) begin
            r_acc <= n_sum;
        end
        if (r_p_valid && r_p_tag.last) begin
            r_result.c_value     <= n_sum;
            r_result.c_row       <= r_p_tag.row;
            r_result.c_col       <= r_p_tag.col;
            r_result.row_last    <= r_p_tag.row_last;
            r_result.matrix_last <= r_p_tag.matrix_last;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_result   = r_result;
    assign o_row_done = r_p_valid && r_p_tag.last && r_p_tag.row_last;

endmodule
`default_nettype wire

[sv/imm_core.sv]
// Sequencer, B store and A row buffer that feed the shared multiply-accumulate unit.
`default_nettype none
module imm_core #(
    parameter int B_DEPTH   = imm_pkg::DEF_B_DEPTH,
    parameter int ROW_DEPTH = imm_pkg::DEF_ROW_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire imm_pkg::t_dims   i_dims,
    input  wire logic             i_start,
    input  wire imm_pkg::t_in_item i_item,
    output logic                  o_busy,
    output logic                  o_strobe,
    output imm_pkg::t_out_item    o_result
);
    import imm_pkg::*;

    localparam int BAW = $clog2(B_DEPTH);
    localparam int RAW = $clog2(ROW_DEPTH);

    t_state r_state, n_state;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_bdone, n_bdone;
    logic [DIM_W-1:0]  r_acol, n_acol;
    logic [DIM_W-1:0]  r_arow, n_arow;
    logic [DIM_W-1:0]  r_crow, n_crow;
    logic              r_mlast, n_mlast;
    logic [DIM_W-1:0]  r_k, n_k;
    logic [DIM_W-1:0]  r_j, n_j;
    logic [FILL_W-1:0] r_bidx, n_bidx;

    logic [DATA_W-1:0] b_mem [B_DEPTH];
    logic [DATA_W-1:0] a_mem [ROW_DEPTH];
    logic [DATA_W-1:0] r_b_q, r_a_q;
    logic              r1_valid, r1_oob;
    t_tag              r1_tag;

    logic              accept, go, b_we, a_we;
    logic              issue_valid, j_last, k_last, row_done;
    logic [FILL_W-1:0] base, b_waddr;
    logic [2*DIM_W-1:0] total;
    t_tag              tag;

    assign accept = i_start && (r_state == S_IDLE);
    assign total  = i_dims.inner * i_dims.cols;
    assign j_last = (r_j == i_dims.inner - DIM_W'(1));
    assign k_last = (r_k == i_dims.cols - DIM_W'(1));
    assign base   = r_bdone ? '0 : r_fill;

    always_comb begin
        n_fill  = r_fill;
        n_bdone = r_bdone;
        n_acol  = r_acol;
        n_arow  = r_arow;
        n_crow  = r_crow;
        n_mlast = r_mlast;
        b_we    = 1'b0;
        a_we    = 1'b0;
        go      = 1'b0;
        b_waddr = base;
        if (i_clear) begin
            n_fill  = '0;
            n_bdone = 1'b0;
            n_acol  = '0;
            n_arow  = '0;
        end else if (accept) begin
            if (i_item.func == FUNC_B) begin
                if (r_bdone) begin
                    n_acol = '0;
                    n_arow = '0;
                end
                b_we    = (base < FILL_W'(B_DEPTH));
                n_fill  = base + FILL_W'(1);
                n_bdone = (base + FILL_W'(1)) >= FILL_W'(total);
            end else if (r_bdone) begin
                a_we = 1'b1;
                if ((DIM_W+1)'(r_acol) + (DIM_W+1)'(1) < (DIM_W+1)'(i_dims.inner)) begin
                    n_acol = r_acol + DIM_W'(1);
                end else begin
                    n_acol  = '0;
                    go      = 1'b1;
                    n_crow  = r_arow;
                    n_mlast = ((DIM_W+1)'(r_arow) + (DIM_W+1)'(1) >=
                               (DIM_W+1)'(i_dims.rows));
                    n_arow  = n_mlast ? '0 : r_arow + DIM_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (go) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (j_last && k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (row_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        issue_valid = 1'b0;
        o_busy      = 1'b1;
        case (r_state)
            S_IDLE:  o_busy = 1'b0;
            S_ISSUE: issue_valid = 1'b1;
            S_DRAIN: issue_valid = 1'b0;
            default: o_busy = 1'b0;
        endcase
    end

    always_comb begin
        n_k    = r_k;
        n_j    = r_j;
        n_bidx = r_bidx;
        if (go) begin
            n_k    = '0;
            n_j    = '0;
            n_bidx = '0;
        end else if (issue_valid) begin
            if (j_last) begin
                n_j    = '0;
                n_k    = r_k + DIM_W'(1);
                n_bidx = FILL_W'(r_k) + FILL_W'(1);
            end else begin
                n_j    = r_j + DIM_W'(1);
                n_bidx = r_bidx + FILL_W'(i_dims.cols);
            end
        end
    end

    always_comb begin
        tag.first       = (r_j == '0);
        tag.last        = j_last;
        tag.col         = r_k[IDX_W-1:0];
        tag.row         = r_crow[IDX_W-1:0];
        tag.row_last    = k_last;
        tag.matrix_last = k_last && r_mlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_bdone  <= 1'b0;
            r_acol   <= '0;
            r_arow   <= '0;
            r1_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_bdone  <= n_bdone;
            r_acol   <= n_acol;
            r_arow   <= n_arow;
            r1_valid <= issue_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crow  <= n_crow;
        r_mlast <= n_mlast;
        r_k     <= n_k;
        r_j     <= n_j;
        r_bidx  <= n_bidx;
        r1_tag  <= tag;
        r1_oob  <= !(r_bidx < FILL_W'(B_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            b_mem[b_waddr[BAW-1:0]] <= i_item.value;
        end
        r_b_q <= b_mem[r_bidx[BAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            a_mem[r_acol[RAW-1:0]] <= i_item.value;
        end
        r_a_q <= a_mem[r_j[RAW-1:0]];
    end

    imm_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r1_valid),
        .i_a        (r_a_q),
        .i_b        (r1_oob ? '0 : r_b_q),
        .i_tag      (r1_tag),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .o_row_done (row_done)
    );

endmodule
`default_nettype wire

[sv/integer_matrix_multiply_top.sv]
// Top level of the integer matrix multiply block with its configuration registers.
//
// The block computes C = A x B on signed 32-bit elements, wrapping to 32 bits.
// Configuration goes through the APB port: rows_a at 0x0, inner_dim at 0x4 and
// cols_b at 0x8; any write to one of them restarts the B load and the A row count.
// A transaction on the command side is taken when start is high and busy is low.
// A B element or an A element that does not end a row leaves busy low. The element
// that ends a row of A starts the shared multiply-accumulate unit, which does one
// product per cycle on its single multiplier, fed by registered reads of the B
// store and the A row buffer; busy stays high until the last sum of the row is
// accumulated. The results of the row appear on o_result, each with o_strobe
// high for exactly one cycle, the last in the first cycle in which busy is low.
// The receiver must take each result in the cycle it is shown.
// After reset the registers hold 1, no B is loaded and the store contents are
// undefined; the block is ready at once.
`default_nettype none
module integer_matrix_multiply_top #(
    parameter int MAX_DIM   = imm_pkg::DEF_MAX_DIM,
    parameter int B_DEPTH   = imm_pkg::DEF_B_DEPTH,
    parameter int ROW_DEPTH = imm_pkg::DEF_ROW_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [imm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        start,
    input  wire imm_pkg::t_in_item           i_data,
    output logic                             busy,
    output logic                             o_strobe,
    output imm_pkg::t_out_item               o_result
);
    import imm_pkg::*;

    localparam int INNER_CAP = (MAX_DIM < ROW_DEPTH) ? MAX_DIM : ROW_DEPTH;
    localparam int COLS_CAP  = (MAX_DIM < MAX_OUT) ? MAX_DIM : MAX_OUT;

    logic [DIM_W-1:0] r_rows, r_inner, r_cols;
    logic             wr, clear;
    t_dims            dims;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_comb begin
        clear = 1'b0;
        if (wr) begin
            case (paddr[3:2])
                REG_ROWS_A, REG_INNER_DIM, REG_COLS_B: clear = 1'b1;
                default: clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_W'(1);
            r_inner <= DIM_W'(1);
            r_cols  <= DIM_W'(1);
        end else if (wr) begin
            case (paddr[3:2])
                REG_ROWS_A:    r_rows  <= pwdata[DIM_W-1:0];
                REG_INNER_DIM: r_inner <= pwdata[DIM_W-1:0];
                REG_COLS_B:    r_cols  <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROWS_A:    prdata = 32'(r_rows);
            REG_INNER_DIM: prdata = 32'(r_inner);
            REG_COLS_B:    prdata = 32'(r_cols);
            default:       prdata = '0;
        endcase
    end

    assign dims.rows  = clamp_dim(r_rows, MAX_DIM);
    assign dims.inner = clamp_dim(r_inner, INNER_CAP);
    assign dims.cols  = clamp_dim(r_cols, COLS_CAP);

    imm_core #(
        .B_DEPTH   (B_DEPTH),
        .ROW_DEPTH (ROW_DEPTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (clear),
        .i_dims   (dims),
        .i_start  (start),
        .i_item   (i_data),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
